// ===== rtl/rrts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types, codes and sizes for the round-robin time-slice scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

    // table and id sizing
    localparam int MAX_PROCESSES = 16;
    localparam int ID_WIDTH      = 16;
    localparam int SLOT_W        = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int CNT_W         = $clog2(MAX_PROCESSES + 1);

    // fixed field widths of the command and result beats
    localparam int OP_W       = 2;
    localparam int PID_W      = 16;
    localparam int IDX_W      = 4;
    localparam int SLICE_W    = 16;
    localparam int STATUS_W   = 2;

    localparam logic [SLICE_W-1:0] SLICE_RESET = 16'd10;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // operation codes
    localparam logic [OP_W-1:0] OP_ADD        = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK       = 2'd1;
    localparam logic [OP_W-1:0] OP_MARK_WAIT  = 2'd2;
    localparam logic [OP_W-1:0] OP_MARK_READY = 2'd3;

    // slot status codes
    localparam logic [1:0] ST_READY   = 2'd0;
    localparam logic [1:0] ST_RUNNING = 2'd1;
    localparam logic [1:0] ST_WAITING = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] RES_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] RES_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] RES_UNUSED = 2'd2;

    // job kinds after classification
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_ADD  = 2'd0;
    localparam t_kind KIND_TICK = 2'd1;
    localparam t_kind KIND_MARK = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [PID_W-1:0] process_id;
        logic [IDX_W-1:0] slot_index;
    } t_cmd;

    typedef struct packed {
        logic                switched;
        logic [PID_W-1:0]    running_id;
        logic [IDX_W-1:0]    running_slot;
        logic [PID_W-1:0]    previous_id;
        logic                had_previous;
        logic [IDX_W-1:0]    assigned_slot;
        logic [STATUS_W-1:0] status;
    } t_result;

    typedef struct packed {
        t_kind               kind;
        logic [1:0]          mark_status;
        logic [ID_WIDTH-1:0] pid;
        logic [IDX_W-1:0]    slot;
    } t_job;

endpackage

// ===== rtl/round_robin_time_slice_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_time_slice_scheduler
// Round-robin process scheduler with a per-process time slice.
// Commands pass through the front holding register, the job queue and the
// back end job register before the result register; a tick that ends a slice
// also runs the slot search, which checks one slot per cycle, and on a switch the id load.
// The back end takes a new job only once the last one has retired; the
// receiver cannot stall, results are strobed for one cycle on o_done.
// Reset (synchronous, active low) empties the table, the queue and the
// current process and sets slice_length to 10.
// ----------------------------------------------------------------------------
module round_robin_time_slice_scheduler import rrts_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  t_cmd               i_cmd,
    output logic               busy,
    input  logic               i_cfg_valid,
    input  logic [SLICE_W-1:0] i_cfg_data,
    output logic               o_cfg_ready,
    output logic               o_done,
    output t_result            o_result
);

    logic [SLICE_W-1:0] r_slice_length;
    logic               push;
    t_job               front_job;
    logic               q_full;
    logic               q_valid;
    t_job               q_job;
    logic               q_pop;

    // slice length register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slice_length <= SLICE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_slice_length <= i_cfg_data;
        end
    end

    // command decode
    rrts_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .busy     (busy),
        .o_push   (push),
        .o_job    (front_job),
        .i_q_full (q_full)
    );

    // job queue
    rrts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    // table and scheduling
    rrts_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_valid    (q_valid),
        .i_job          (q_job),
        .o_job_pop      (q_pop),
        .i_slice_length (r_slice_length),
        .o_done         (o_done),
        .o_result       (o_result)
    );

endmodule

// ===== rtl/rrts_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_front
// Takes command beats, decodes them into jobs and hands them to the queue.
// ----------------------------------------------------------------------------
module rrts_front import rrts_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_cmd i_cmd,
    output logic busy,
    output logic o_push,
    output t_job o_job,
    input  logic i_q_full
);

    logic r_valid;
    logic n_valid;
    t_job r_job;
    t_job n_job;
    logic accept;

    // holding register stalls only when the queue is full
    assign busy   = r_valid && i_q_full;
    assign accept = start && !busy;
    assign o_push = r_valid;
    assign o_job  = r_job;

    // classify the command
    always_comb begin
        n_job             = r_job;
        n_job.pid         = ID_WIDTH'(i_cmd.process_id);
        n_job.slot        = i_cmd.slot_index;
        n_job.mark_status = ST_READY;
        case (i_cmd.operation)
            OP_ADD: begin
                n_job.kind = KIND_ADD;
            end
            OP_TICK: begin
                n_job.kind = KIND_TICK;
            end
            OP_MARK_WAIT: begin
                n_job.kind        = KIND_MARK;
                n_job.mark_status = ST_WAITING;
            end
            OP_MARK_READY: begin
                n_job.kind        = KIND_MARK;
                n_job.mark_status = ST_READY;
            end
            default: begin
                n_job.kind = KIND_TICK;
            end
        endcase
    end

    // holding register occupancy
    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (r_valid && !i_q_full) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_job <= n_job;
        end
    end

endmodule

// ===== rtl/rrts_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_queue
// Short job queue that lets the front and back stall independently.
// ----------------------------------------------------------------------------
module rrts_queue import rrts_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    t_job              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic [QPTR_W-1:0] n_wp;
    logic [QPTR_W-1:0] n_rp;
    logic [QCNT_W-1:0] n_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_q[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // pointer and fill level update
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + QPTR_W'(1);
        end
        if (do_pop) begin
            n_rp = (r_rp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + QPTR_W'(1);
        end
        case ({do_push, do_pop})
            2'b10:   n_cnt = r_cnt + QCNT_W'(1);
            2'b01:   n_cnt = r_cnt - QCNT_W'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wp] <= i_job;
        end
    end

endmodule

// ===== rtl/rrts_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_back
// Executes jobs against the process table: adds, marks, ticks and the
// circular search for the next ready slot, one slot per cycle.
// ----------------------------------------------------------------------------
module rrts_back import rrts_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_valid,
    input  t_job               i_job,
    output logic               o_job_pop,
    input  logic [SLICE_W-1:0] i_slice_length,
    output logic               o_done,
    output t_result            o_result
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_SWAP = 3'd3;
    localparam logic [2:0] S_LOAD = 3'd4;

    // control state
    logic [2:0]          r_state,   n_state;
    logic [CNT_W-1:0]    r_count,   n_count;
    logic [SLOT_W-1:0]   r_cur,     n_cur;
    logic                r_have,    n_have;
    logic [SLICE_W-1:0]  r_slice,   n_slice;
    logic [SLOT_W-1:0]   r_ptr,     n_ptr;
    logic [CNT_W-1:0]    r_left,    n_left;
    logic [SLOT_W-1:0]   r_found,   n_found;
    logic [1:0]          r_stat [MAX_PROCESSES];
    logic [1:0]          n_stat [MAX_PROCESSES];
    logic                r_done,    n_done;

    // payload state
    t_job                r_job,     n_job;
    logic [ID_WIDTH-1:0] r_run_id,  n_run_id;
    logic                r_sw,      n_sw;
    logic                r_hadp,    n_hadp;
    logic [ID_WIDTH-1:0] r_prev,    n_prev;
    t_result             r_res,     n_res;

    // id memory
    logic [ID_WIDTH-1:0] r_ids [MAX_PROCESSES];
    logic [ID_WIDTH-1:0] r_rd_data;
    logic [SLOT_W-1:0]   rd_addr;
    logic                mem_we;
    logic [SLOT_W-1:0]   wr_addr;

    // scan helpers
    logic [CNT_W-1:0]    ptr_inc;
    logic [SLOT_W-1:0]   ptr_next;
    logic [SLOT_W-1:0]   stat_addr;
    logic [1:0]          stat_rd;

    // per-beat result fields
    logic                e_emit;
    logic                e_sw;
    logic                e_hadp;
    logic [ID_WIDTH-1:0] e_prev;
    logic [CNT_W-1:0]    e_assigned;
    logic [STATUS_W-1:0] e_status;

    assign o_job_pop = (r_state == S_IDLE) && i_job_valid;
    assign o_done    = r_done;
    assign o_result  = r_res;

    // next slot in circular order within the used part of the table
    assign ptr_inc   = CNT_W'(r_ptr) + CNT_W'(1);
    assign ptr_next  = (ptr_inc == r_count) ? '0 : SLOT_W'(ptr_inc);
    assign stat_addr = (r_state == S_SWAP) ? r_cur : ptr_next;
    assign stat_rd   = r_stat[stat_addr];

    // job sequencer
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_cur      = r_cur;
        n_have     = r_have;
        n_slice    = r_slice;
        n_ptr      = r_ptr;
        n_left     = r_left;
        n_found    = r_found;
        n_stat     = r_stat;
        n_job      = r_job;
        n_run_id   = r_run_id;
        n_sw       = r_sw;
        n_hadp     = r_hadp;
        n_prev     = r_prev;
        rd_addr    = '0;
        mem_we     = 1'b0;
        wr_addr    = SLOT_W'(r_count);
        e_emit     = 1'b0;
        e_sw       = 1'b0;
        e_hadp     = 1'b0;
        e_prev     = '0;
        e_assigned = '0;
        e_status   = RES_OK;
        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    n_job   = i_job;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_job.kind)
                    KIND_ADD: begin
                        e_emit = 1'b1;
                        if (r_count == CNT_W'(MAX_PROCESSES)) begin
                            e_status = RES_FULL;
                        end else begin
                            mem_we          = 1'b1;
                            n_stat[wr_addr] = ST_READY;
                            e_assigned      = r_count;
                            n_count         = r_count + CNT_W'(1);
                        end
                    end
                    KIND_MARK: begin
                        e_emit = 1'b1;
                        if (32'(r_job.slot) < 32'(r_count)) begin
                            n_stat[SLOT_W'(r_job.slot)] = r_job.mark_status;
                        end else begin
                            e_status = RES_UNUSED;
                        end
                    end
                    KIND_TICK: begin
                        if (!r_have) begin
                            if (r_count == '0) begin
                                e_emit   = 1'b1;
                                e_status = RES_UNUSED;
                            end else begin
                                // first tick starts slot 0
                                n_cur     = '0;
                                n_have    = 1'b1;
                                n_stat[0] = ST_RUNNING;
                                n_slice   = i_slice_length;
                                n_sw      = 1'b1;
                                n_hadp    = 1'b0;
                                n_prev    = '0;
                                rd_addr   = '0;
                                n_state   = S_LOAD;
                            end
                        end else if (r_slice != '0) begin
                            e_emit  = 1'b1;
                            n_slice = r_slice - SLICE_W'(1);
                        end else begin
                            n_ptr   = r_cur;
                            n_left  = r_count - CNT_W'(1);
                            n_state = S_SCAN;
                        end
                    end
                    default: begin
                        e_emit = 1'b1;
                    end
                endcase
            end
            S_SCAN: begin
                if (r_left == '0) begin
                    // nobody else ready: keep running, reload the slice
                    e_emit  = 1'b1;
                    n_slice = i_slice_length;
                end else if (stat_rd == ST_READY) begin
                    n_found = ptr_next;
                    n_state = S_SWAP;
                end else begin
                    n_ptr  = ptr_next;
                    n_left = r_left - CNT_W'(1);
                end
            end
            S_SWAP: begin
                // displaced slot goes back to ready only if still running
                if (stat_rd == ST_RUNNING) begin
                    n_stat[r_cur] = ST_READY;
                end
                n_stat[r_found] = ST_RUNNING;
                n_sw            = 1'b1;
                n_hadp          = 1'b1;
                n_prev          = r_run_id;
                n_cur           = r_found;
                n_slice         = i_slice_length;
                rd_addr         = r_found;
                n_state         = S_LOAD;
            end
            S_LOAD: begin
                n_run_id = r_rd_data;
                e_emit   = 1'b1;
                e_sw     = r_sw;
                e_hadp   = r_hadp;
                e_prev   = r_prev;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (e_emit) begin
            n_state = S_IDLE;
        end
        n_done = e_emit;
    end

    // result beat from the state after the job
    always_comb begin
        n_res               = r_res;
        n_res.switched      = e_sw;
        n_res.running_id    = n_have ? PID_W'(n_run_id) : '0;
        n_res.running_slot  = n_have ? IDX_W'(n_cur) : '0;
        n_res.previous_id   = PID_W'(e_prev);
        n_res.had_previous  = e_hadp;
        n_res.assigned_slot = IDX_W'(e_assigned);
        n_res.status        = e_status;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_cur   <= '0;
            r_have  <= 1'b0;
            r_slice <= '0;
            r_ptr   <= '0;
            r_left  <= '0;
            r_found <= '0;
            r_done  <= 1'b0;
            for (int i = 0; i < MAX_PROCESSES; i++) begin
                r_stat[i] <= ST_READY;
            end
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_cur   <= n_cur;
            r_have  <= n_have;
            r_slice <= n_slice;
            r_ptr   <= n_ptr;
            r_left  <= n_left;
            r_found <= n_found;
            r_done  <= n_done;
            r_stat  <= n_stat;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_job    <= n_job;
        r_run_id <= n_run_id;
        r_sw     <= n_sw;
        r_hadp   <= n_hadp;
        r_prev   <= n_prev;
        if (e_emit) begin
            r_res <= n_res;
        end
    end

    // id memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_ids[wr_addr] <= r_job.pid;
        end
        r_rd_data <= r_ids[rd_addr];
    end

endmodule
